// ===== hdl/scr_pkg.sv =====
// Package: shared types, codes, the frame byte functions and the CRC-8 function for the SPI register access block.
`timescale 1ns / 1ps

package scr_pkg;

    localparam int SCR_BYTES_PER_ACCESS = 2;

    localparam logic [3:0] SCR_MAX_ATTEMPTS_RESET = 4'd4;

    // Request type codes.
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_ECHO  = 2'd2;

    // Result kind codes.
    localparam logic RES_FRAME  = 1'b0;
    localparam logic RES_FINISH = 1'b1;

    localparam logic [7:0] CRC_POLY      = 8'h07;
    localparam logic [7:0] WRITE_FLAG    = 8'h80;
    localparam logic [7:0] READ_FILLER   = 8'hFF;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [6:0]  reg_addr;
        logic [15:0] write_data;
        logic [7:0]  echo_first;
        logic [7:0]  echo_second;
    } req_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  frame_addr;
        logic [7:0]  frame_data;
        logic [7:0]  frame_crc;
        logic        access_ok;
        logic [15:0] read_word;
    } res_item_t;

    // CRC-8, MSB first, zero initial value, no final xor, over two bytes.
    function automatic logic [7:0] scr_crc8(input logic [7:0] first, input logic [7:0] second);
        logic [7:0] crc;
        crc = first;
        for (int i = 0; i < 8; i++)
        begin
            crc = crc[7] ? ({crc[6:0], 1'b0} ^ CRC_POLY) : {crc[6:0], 1'b0};
        end
        crc = crc ^ second;
        for (int i = 0; i < 8; i++)
        begin
            crc = crc[7] ? ({crc[6:0], 1'b0} ^ CRC_POLY) : {crc[6:0], 1'b0};
        end
        return crc;
    endfunction

    // Address byte of a frame: address with bit 7 set on writes, plus byte index (8-bit sum, may wrap).
    function automatic logic [7:0] scr_addr_byte(input logic is_wr, input logic [6:0] addr,
                                                 input logic [7:0] idx);
        logic [7:0] base;
        base = {1'b0, addr} | (is_wr ? WRITE_FLAG : 8'h00);
        return base + idx;
    endfunction

    // Data byte of a frame: write data low byte first, filler on reads.
    function automatic logic [7:0] scr_data_byte(input logic is_wr, input logic [15:0] value,
                                                 input logic [7:0] idx);
        logic [7:0] data;
        if (!is_wr)
        begin
            data = READ_FILLER;
        end
        else if (idx == 8'd0)
        begin
            data = value[7:0];
        end
        else if (idx == 8'd1)
        begin
            data = value[15:8];
        end
        else
        begin
            data = 8'h00;
        end
        return data;
    endfunction

endpackage

// ===== hdl/scr_req_if.sv =====
// Interface: request channel carrying one input beat.
`timescale 1ns / 1ps

interface scr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [6:0]  reg_addr;
    logic [15:0] write_data;
    logic [7:0]  echo_first;
    logic [7:0]  echo_second;

    modport source (output valid, output req_type, output reg_addr, output write_data,
                    output echo_first, output echo_second, input ready);
    modport sink   (input valid, input req_type, input reg_addr, input write_data,
                    input echo_first, input echo_second, output ready);
endinterface

// ===== hdl/scr_res_if.sv =====
// Interface: result channel carrying one result beat.
`timescale 1ns / 1ps

interface scr_res_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  frame_addr;
    logic [7:0]  frame_data;
    logic [7:0]  frame_crc;
    logic        access_ok;
    logic [15:0] read_word;

    modport source (output valid, output result_kind, output frame_addr, output frame_data,
                    output frame_crc, output access_ok, output read_word, input ready);
    modport sink   (input valid, input result_kind, input frame_addr, input frame_data,
                    input frame_crc, input access_ok, input read_word, output ready);
endinterface

// ===== hdl/scr_cfg_if.sv =====
// Interface: configuration write channel for the attempt limit.
`timescale 1ns / 1ps

interface scr_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] max_attempts;

    modport source (output valid, output max_attempts, input ready);
    modport sink   (input valid, input max_attempts, output ready);
endinterface

// ===== hdl/scr_in_stage.sv =====
// Input register stage: holds one accepted request beat until the engine takes it.
`timescale 1ns / 1ps

module scr_in_stage
    import scr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  req_item_t in_item,
    output logic      in_ready,
    input  logic      take,
    output logic      stage_valid,
    output req_item_t stage_item
);

    logic      valid_reg;
    logic      valid_next;
    req_item_t item_reg;

    assign in_ready    = !valid_reg || take;
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== hdl/scr_engine.sv =====
// Exchange engine: access state, echo check, retry count and frame/finish result.
`timescale 1ns / 1ps

module scr_engine
    import scr_pkg::*;
#(
    parameter int BYTES_PER_ACCESS = SCR_BYTES_PER_ACCESS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  req_item_t item,
    input  logic [3:0] max_attempts,
    output logic      has_result,
    output res_item_t result
);

    localparam int IDX_W = $clog2(BYTES_PER_ACCESS + 1);
    localparam logic [IDX_W-1:0] LAST_COUNT = IDX_W'(BYTES_PER_ACCESS);

    logic             busy_reg,     busy_next;
    logic             is_write_reg, is_write_next;
    logic [IDX_W-1:0] idx_reg,      idx_next;
    logic [3:0]       att_reg,      att_next;
    logic [6:0]       addr_reg,     addr_next;
    logic [15:0]      value_reg,    value_next;
    logic [7:0]       cap_lo_reg,   cap_lo_next;
    logic [7:0]       cap_hi_reg,   cap_hi_next;

    logic [7:0] cur_addr;
    logic [7:0] cur_data;
    logic [7:0] frm_addr;
    logic [7:0] frm_data;
    logic [3:0] limit;
    logic       match;
    logic       emit_frame;
    logic       emit_finish;
    logic       finish_ok;

    assign cur_addr = scr_addr_byte(is_write_reg, addr_reg, 8'(idx_reg));
    assign cur_data = scr_data_byte(is_write_reg, value_reg, 8'(idx_reg));
    assign limit    = (max_attempts == 4'd0) ? 4'd1 : max_attempts;
    assign match    = (item.echo_first == cur_addr)
                      && (!is_write_reg || (item.echo_second == cur_data));

    // Next state and which kind of result this beat produces.
    always_comb
    begin
        busy_next     = busy_reg;
        is_write_next = is_write_reg;
        idx_next      = idx_reg;
        att_next      = att_reg;
        addr_next     = addr_reg;
        value_next    = value_reg;
        cap_lo_next   = cap_lo_reg;
        cap_hi_next   = cap_hi_reg;
        emit_frame    = 1'b0;
        emit_finish   = 1'b0;
        finish_ok     = 1'b0;
        unique case (item.req_type)
            REQ_WRITE, REQ_READ:
            begin
                busy_next     = 1'b1;
                is_write_next = (item.req_type == REQ_WRITE);
                idx_next      = '0;
                att_next      = 4'd1;
                addr_next     = item.reg_addr;
                value_next    = (item.req_type == REQ_WRITE) ? item.write_data : 16'h0000;
                cap_lo_next   = 8'h00;
                cap_hi_next   = 8'h00;
                emit_frame    = 1'b1;
            end
            REQ_ECHO:
            begin
                if (busy_reg)
                begin
                    if (!match)
                    begin
                        if (att_reg >= limit)
                        begin
                            busy_next   = 1'b0;
                            emit_finish = 1'b1;
                        end
                        else
                        begin
                            att_next   = att_reg + 4'd1;
                            emit_frame = 1'b1;
                        end
                    end
                    else
                    begin
                        if (!is_write_reg && (idx_reg == IDX_W'(0)))
                        begin
                            cap_lo_next = item.echo_second;
                        end
                        if (!is_write_reg && (idx_reg == IDX_W'(1)))
                        begin
                            cap_hi_next = item.echo_second;
                        end
                        idx_next = idx_reg + IDX_W'(1);
                        att_next = 4'd1;
                        if (idx_next >= LAST_COUNT)
                        begin
                            busy_next   = 1'b0;
                            emit_finish = 1'b1;
                            finish_ok   = 1'b1;
                        end
                        else
                        begin
                            emit_frame = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // The frame always reflects the state after this beat.
    assign frm_addr = scr_addr_byte(is_write_next, addr_next, 8'(idx_next));
    assign frm_data = scr_data_byte(is_write_next, value_next, 8'(idx_next));

    always_comb
    begin
        has_result         = emit_frame || emit_finish;
        result.result_kind = emit_finish ? RES_FINISH : RES_FRAME;
        result.frame_addr  = emit_frame ? frm_addr : 8'h00;
        result.frame_data  = emit_frame ? frm_data : 8'h00;
        result.frame_crc   = emit_frame ? scr_crc8(frm_addr, frm_data) : 8'h00;
        result.access_ok   = emit_finish && finish_ok;
        result.read_word   = (emit_finish && finish_ok && !is_write_reg)
                             ? {cap_hi_next, cap_lo_next} : 16'h0000;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            is_write_reg <= 1'b0;
            idx_reg      <= '0;
            att_reg      <= 4'd0;
            addr_reg     <= 7'd0;
            value_reg    <= 16'h0000;
            cap_lo_reg   <= 8'h00;
            cap_hi_reg   <= 8'h00;
        end
        else if (fire)
        begin
            busy_reg     <= busy_next;
            is_write_reg <= is_write_next;
            idx_reg      <= idx_next;
            att_reg      <= att_next;
            addr_reg     <= addr_next;
            value_reg    <= value_next;
            cap_lo_reg   <= cap_lo_next;
            cap_hi_reg   <= cap_hi_next;
        end
    end

endmodule

// ===== hdl/scr_out_stage.sv =====
// Output register stage: holds one result beat until the sink takes it.
`timescale 1ns / 1ps

module scr_out_stage
    import scr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  res_item_t load_item,
    output logic      free,
    input  logic      out_ready,
    output logic      out_valid,
    output res_item_t out_item
);

    logic      valid_reg;
    logic      valid_next;
    res_item_t item_reg;

    // A slot is free when empty or when the held beat leaves this cycle.
    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= load_item;
        end
    end

endmodule

// ===== hdl/spi_crc_register_access_with_echo_retry.sv =====
// Top level: SPI register access host with CRC-8 frames and echo retry.
// Throughput: one request beat per cycle while the sink keeps ready high;
// the input and output registers each hold one beat,
// so a request is taken while a finished result still waits for the sink.
// Each beat's work (echo compare, retry count, CRC-8) is one combinational pass between them.
// Reset (rst_n low, asynchronous) empties both registers, idles the access, sets the limit to 4.
`timescale 1ns / 1ps

module spi_crc_register_access_with_echo_retry
    import scr_pkg::*;
#(
    parameter int BYTES_PER_ACCESS = SCR_BYTES_PER_ACCESS
)
(
    input  logic     clk,
    input  logic     rst_n,
    scr_req_if.sink  req,
    scr_res_if.source res,
    scr_cfg_if.sink  cfg
);

    logic [3:0] max_attempts_reg;
    req_item_t  in_item;
    req_item_t  stage_item;
    logic       stage_valid;
    logic       take;
    logic       out_free;
    logic       has_result;
    res_item_t  eng_result;
    res_item_t  out_item;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_attempts_reg <= SCR_MAX_ATTEMPTS_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            max_attempts_reg <= cfg.max_attempts;
        end
    end

    assign in_item.req_type    = req.req_type;
    assign in_item.reg_addr    = req.reg_addr;
    assign in_item.write_data  = req.write_data;
    assign in_item.echo_first  = req.echo_first;
    assign in_item.echo_second = req.echo_second;

    assign take = stage_valid && out_free;

    scr_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_item     (in_item),
        .in_ready    (req.ready),
        .take        (take),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    scr_engine #(
        .BYTES_PER_ACCESS (BYTES_PER_ACCESS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (take),
        .item         (stage_item),
        .max_attempts (max_attempts_reg),
        .has_result   (has_result),
        .result       (eng_result)
    );

    scr_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take && has_result),
        .load_item (eng_result),
        .free      (out_free),
        .out_ready (res.ready),
        .out_valid (res.valid),
        .out_item  (out_item)
    );

    assign res.result_kind = out_item.result_kind;
    assign res.frame_addr  = out_item.frame_addr;
    assign res.frame_data  = out_item.frame_data;
    assign res.frame_crc   = out_item.frame_crc;
    assign res.access_ok   = out_item.access_ok;
    assign res.read_word   = out_item.read_word;

endmodule

// ===== hdl/scr_checker.sv =====
// Checker: port-level assertions on result beats, bound to the top level.
`timescale 1ns / 1ps

module scr_checker
    import scr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic        result_kind,
    input logic [7:0]  frame_addr,
    input logic [7:0]  frame_data,
    input logic [7:0]  frame_crc,
    input logic        access_ok,
    input logic [15:0] read_word
);

    // Every frame carries the CRC of its own two bytes.
    a_frame_crc: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (result_kind == RES_FRAME)) |-> (frame_crc == scr_crc8(frame_addr, frame_data)))
        else $error("frame CRC does not match frame bytes");

    // A finish beat carries no frame bytes.
    a_finish_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (result_kind == RES_FINISH))
            |-> ((frame_addr == 8'h00) && (frame_data == 8'h00) && (frame_crc == 8'h00)))
        else $error("finish beat carries frame bytes");

    // A frame beat carries no status and no word; a failed finish carries no word.
    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && ((result_kind == RES_FRAME) || !access_ok)) |-> (read_word == 16'h0000))
        else $error("read word set outside a successful finish");

    a_frame_no_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (result_kind == RES_FRAME)) |-> !access_ok)
        else $error("frame beat reports access status");

    // A stalled result beat holds its kind, frame address, CRC and read word.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(result_kind) && $stable(frame_addr)
            && $stable(frame_crc) && $stable(read_word)))
        else $error("stalled result beat changed");

endmodule

bind spi_crc_register_access_with_echo_retry scr_checker u_scr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .result_kind (res.result_kind),
    .frame_addr  (res.frame_addr),
    .frame_data  (res.frame_data),
    .frame_crc   (res.frame_crc),
    .access_ok   (res.access_ok),
    .read_word   (res.read_word)
);

// ===== test/tb_spi_crc_register_access_with_echo_retry.sv =====
// Testbench: CRC-8 framed SPI register access host, random and directed echo exchanges.
`timescale 1ns / 1ps

module tb_spi_crc_register_access_with_echo_retry;
    import scr_pkg::*;

    // The one request code that the block has no use for.
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int TARGET_ITEMS = 1850;
    localparam int PHASES = 8;

    // Tracks the access in progress and holds the result beats it should produce.
    class access_tracker;
        logic [3:0]  attempt_limit;
        bit          busy;
        bit          wr;
        logic [7:0]  idx;
        logic [3:0]  sends;
        logic [6:0]  addr;
        logic [15:0] value;
        logic [7:0]  cap_lo;
        logic [7:0]  cap_hi;
        res_item_t   expected_results[$];
        int unsigned failures;

        function new();
            attempt_limit = SCR_MAX_ATTEMPTS_RESET;
            busy = 1'b0;
            wr = 1'b0;
            idx = 8'd0;
            sends = 4'd0;
            addr = 7'd0;
            value = 16'd0;
            cap_lo = 8'd0;
            cap_hi = 8'd0;
            failures = 0;
        endfunction

        function logic [7:0] crc8(input logic [7:0] a, input logic [7:0] b);
            logic [15:0] stream;
            logic [7:0]  crc;
            logic        feedback;
            stream = {a, b};
            crc = 8'h00;
            for (int i = 15; i >= 0; i--)
            begin
                feedback = crc[7] ^ stream[i];
                crc = {crc[6:0], 1'b0} ^ (feedback ? CRC_POLY : 8'h00);
            end
            return crc;
        endfunction

        function logic [7:0] frame_addr_byte();
            return ({1'b0, addr} | (wr ? WRITE_FLAG : 8'h00)) + idx;
        endfunction

        function logic [7:0] frame_data_byte();
            if (!wr)
                return READ_FILLER;
            if (idx == 8'd0)
                return value[7:0];
            if (idx == 8'd1)
                return value[15:8];
            return 8'h00;
        endfunction

        function void push_frame();
            res_item_t r;
            r = '0;
            r.result_kind = RES_FRAME;
            r.frame_addr = frame_addr_byte();
            r.frame_data = frame_data_byte();
            r.frame_crc = crc8(r.frame_addr, r.frame_data);
            expected_results.push_back(r);
        endfunction

        function void push_finish(input bit ok, input logic [15:0] word);
            res_item_t r;
            r = '0;
            r.result_kind = RES_FINISH;
            r.access_ok = ok;
            r.read_word = word;
            busy = 1'b0;
            expected_results.push_back(r);
        endfunction

        // Returns 1 when the accepted request beat is due a result beat.
        function bit note_request(input req_item_t it);
            bit         match;
            logic [3:0] lim;
            if (it.req_type == REQ_WRITE || it.req_type == REQ_READ)
            begin
                busy = 1'b1;
                wr = (it.req_type == REQ_WRITE);
                idx = 8'd0;
                sends = 4'd1;
                addr = it.reg_addr;
                value = wr ? it.write_data : 16'd0;
                cap_lo = 8'd0;
                cap_hi = 8'd0;
                push_frame();
                return 1'b1;
            end
            if (it.req_type != REQ_ECHO || !busy)
                return 1'b0;
            if (wr)
                match = (it.echo_first == frame_addr_byte()) &&
                        (it.echo_second == frame_data_byte());
            else
                match = (it.echo_first == frame_addr_byte());
            if (!match)
            begin
                lim = (attempt_limit == 4'd0) ? 4'd1 : attempt_limit;
                if (sends >= lim)
                begin
                    push_finish(1'b0, 16'd0);
                end
                else
                begin
                    sends = sends + 4'd1;
                    push_frame();
                end
                return 1'b1;
            end
            if (!wr)
            begin
                if (idx == 8'd0)
                    cap_lo = it.echo_second;
                else if (idx == 8'd1)
                    cap_hi = it.echo_second;
            end
            idx = idx + 8'd1;
            sends = 4'd1;
            if (idx >= SCR_BYTES_PER_ACCESS)
                push_finish(1'b1, wr ? 16'd0 : {cap_hi, cap_lo});
            else
                push_frame();
            return 1'b1;
        endfunction

        function void check_result(input res_item_t got);
            res_item_t want;
            if (expected_results.size() == 0)
            begin
                $error("result beat with no expectation waiting: kind %0d", got.result_kind);
                failures++;
                return;
            end
            want = expected_results.pop_front();
            if (got.result_kind !== want.result_kind)
            begin
                $error("result_kind: expected %0h, got %0h", want.result_kind, got.result_kind);
                failures++;
            end
            if (got.frame_addr !== want.frame_addr)
            begin
                $error("frame_addr: expected %0h, got %0h", want.frame_addr, got.frame_addr);
                failures++;
            end
            if (got.frame_data !== want.frame_data)
            begin
                $error("frame_data: expected %0h, got %0h", want.frame_data, got.frame_data);
                failures++;
            end
            if (got.frame_crc !== want.frame_crc)
            begin
                $error("frame_crc: expected %0h, got %0h", want.frame_crc, got.frame_crc);
                failures++;
            end
            if (got.access_ok !== want.access_ok)
            begin
                $error("access_ok: expected %0h, got %0h", want.access_ok, got.access_ok);
                failures++;
            end
            if (got.read_word !== want.read_word)
            begin
                $error("read_word: expected %0h, got %0h", want.read_word, got.read_word);
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   quiet;
    int   live_items;

    access_tracker sb = new();

    scr_req_if req_bus();
    scr_res_if res_bus();
    scr_cfg_if cfg_bus();

    spi_crc_register_access_with_echo_retry i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .res   (res_bus),
        .cfg   (cfg_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // Holds a request beat until the block takes it, then updates the expectations.
    task automatic drive_req(input req_item_t it);
        req_bus.valid <= 1'b1;
        req_bus.req_type <= it.req_type;
        req_bus.reg_addr <= it.reg_addr;
        req_bus.write_data <= it.write_data;
        req_bus.echo_first <= it.echo_first;
        req_bus.echo_second <= it.echo_second;
        @(posedge clk);
        while (req_bus.ready !== 1'b1)
            @(posedge clk);
        if (sb.note_request(it))
            live_items++;
    endtask

    task automatic send_start(input logic [1:0] kind, input logic [6:0] addr,
                              input logic [15:0] data);
        req_item_t it;
        it.req_type = kind;
        it.reg_addr = addr;
        it.write_data = data;
        it.echo_first = 8'($urandom);
        it.echo_second = 8'($urandom);
        drive_req(it);
    endtask

    // Echoes the frame in flight; a corrupted echo breaks a byte that is compared.
    task automatic send_echo(input bit corrupt, input logic [7:0] read_byte);
        req_item_t it;
        int        pick;
        it.req_type = REQ_ECHO;
        it.reg_addr = 7'($urandom);
        it.write_data = 16'($urandom);
        it.echo_first = sb.frame_addr_byte();
        it.echo_second = sb.wr ? sb.frame_data_byte() : read_byte;
        if (corrupt)
        begin
            pick = sb.wr ? $urandom_range(0, 2) : 0;
            if (pick != 1)
                it.echo_first = it.echo_first ^ 8'($urandom_range(1, 255));
            if (pick != 0)
                it.echo_second = it.echo_second ^ 8'($urandom_range(1, 255));
        end
        drive_req(it);
    endtask

    task automatic send_noise(input logic [1:0] kind);
        req_item_t it;
        it.req_type = kind;
        it.reg_addr = 7'($urandom);
        it.write_data = 16'($urandom);
        it.echo_first = 8'($urandom);
        it.echo_second = 8'($urandom);
        drive_req(it);
    endtask

    task automatic idle_sender();
        int n;
        if (quiet || $urandom_range(0, 99) >= 35)
            return;
        n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 40);
        req_bus.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Lets every expected beat drain, then idles on so that an echo that produced nothing also clears.
    task automatic drain();
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_attempt_limit(input logic [3:0] limit);
        drain();
        cfg_bus.valid <= 1'b1;
        cfg_bus.max_attempts <= limit;
        @(posedge clk);
        while (cfg_bus.ready !== 1'b1)
            @(posedge clk);
        cfg_bus.valid <= 1'b0;
        sb.attempt_limit = limit;
    endtask

    task automatic run_random(input int target);
        int        r;
        bit        stubborn;
        logic [6:0] addr;
        logic [15:0] data;
        while (live_items < target)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            idle_sender();
            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                send_noise((sb.busy || r < 2) ? REQ_UNUSED : REQ_ECHO);
                continue;
            end
            if (r == 99)
                drain();
            r = $urandom_range(0, 9);
            addr = (r == 0) ? 7'd0 : (r == 1) ? 7'd127 : 7'($urandom);
            r = $urandom_range(0, 19);
            data = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
            send_start($urandom_range(0, 1) ? REQ_WRITE : REQ_READ, addr, data);
            stubborn = ($urandom_range(0, 99) < 15);
            while (sb.busy)
            begin
                idle_sender();
                r = $urandom_range(0, 99);
                // Now and then the access is dropped and the next start lands on it.
                if (r < 3)
                    break;
                send_echo(stubborn ? (r < 90) : (r < 20), 8'($urandom));
            end
        end
    endtask

    // Result side: random stalls, with quiet stretches that keep ready high.
    initial
    begin
        res_item_t got;
        int        stall_left;
        stall_left = 0;
        res_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
            begin
                got.result_kind = res_bus.result_kind;
                got.frame_addr = res_bus.frame_addr;
                got.frame_data = res_bus.frame_data;
                got.frame_crc = res_bus.frame_crc;
                got.access_ok = res_bus.access_ok;
                got.read_word = res_bus.read_word;
                sb.check_result(got);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res_bus.ready <= 1'b0;
            end
            else if (rst_n && !quiet && $urandom_range(0, 99) < 30)
            begin
                stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                          : $urandom_range(3, 39);
                res_bus.ready <= 1'b0;
            end
            else
            begin
                res_bus.ready <= rst_n;
            end
        end
    end

    initial
    begin
        logic [3:0] limit_plan [PHASES];
        rst_n = 1'b0;
        quiet = 1'b0;
        live_items = 0;
        req_bus.valid <= 1'b0;
        req_bus.req_type <= REQ_UNUSED;
        req_bus.reg_addr <= 7'd0;
        req_bus.write_data <= 16'd0;
        req_bus.echo_first <= 8'd0;
        req_bus.echo_second <= 8'd0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.max_attempts <= 4'd0;
        limit_plan = '{4'd15, 4'd1, 4'd0, 4'd2, 4'd9, 4'd15, 4'd3, 4'd4};
        limit_plan[4] = 4'($urandom_range(1, 15));
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset attempt limit.
        send_start(REQ_WRITE, 7'd0, 16'h0000);
        send_echo(1'b0, 8'h00);
        send_echo(1'b0, 8'h00);
        // Second frame address wraps from 0xFF to 0x00.
        send_start(REQ_WRITE, 7'd127, 16'hFFFF);
        send_echo(1'b0, 8'h00);
        send_echo(1'b0, 8'h00);
        send_start(REQ_READ, 7'd127, 16'hFFFF);
        send_echo(1'b0, 8'hA5);
        send_echo(1'b0, 8'h5A);
        send_start(REQ_READ, 7'd0, 16'h0000);
        send_echo(1'b0, 8'h00);
        send_echo(1'b0, 8'hFF);
        // Every send of the frame fails, so the access ends with an error.
        send_start(REQ_WRITE, 7'h55, 16'h1234);
        repeat (4) send_echo(1'b1, 8'h00);
        // A start while busy drops the running read.
        send_start(REQ_READ, 7'd10, 16'h0000);
        send_echo(1'b1, 8'h33);
        send_start(REQ_WRITE, 7'd20, 16'hABCD);
        send_echo(1'b0, 8'h00);
        send_echo(1'b0, 8'h00);
        send_noise(REQ_ECHO);
        send_noise(REQ_UNUSED);

        for (int p = 0; p < PHASES; p++)
        begin
            quiet = 1'b0;
            set_attempt_limit(limit_plan[p]);
            run_random(live_items + TARGET_ITEMS / PHASES);
        end

        quiet = 1'b0;
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.failures == 0 && sb.expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
